[hdl/bpqs_pkg.sv]
package bpqs_pkg;

  localparam int unsigned CPUS = 64;

  localparam int unsigned CpuIdxW = 6;
  localparam int unsigned CntW = 16;
  localparam int unsigned AgeW = 40;
  localparam int unsigned QueueW = 3;

  // Only CPUs that a cpu_index can name need counter storage.
  localparam int unsigned StoreDepth = (CPUS < (1 << CpuIdxW)) ? CPUS : (1 << CpuIdxW);
  localparam int unsigned StoreAddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam logic [CntW-1:0] DefFlushBudget = CntW'(3);
  localparam logic [CntW-1:0] DefL0Budget = CntW'(2);
  localparam logic [AgeW-1:0] DefRescueAge = AgeW'(64'd1000000000);
  localparam logic [CntW-1:0] CntMax = '1;

  localparam int unsigned PdataW = 64;
  localparam int unsigned PaddrW = 5;

  typedef enum logic [1:0] {
    RegFlushBudget = 2'd0,
    RegL0Budget = 2'd1,
    RegRescueAge = 2'd2,
    RegUnused = 2'd3
  } reg_idx_e;

  typedef enum logic [QueueW-1:0] {
    QNone = 3'd0,
    QFlush = 3'd1,
    QL0 = 3'd2,
    QComp = 3'd3,
    QShared = 3'd4,
    QRescue = 3'd5,
    QFallback = 3'd6
  } queue_e;

  typedef struct packed {
    logic [CntW-1:0] flush_cap;
    logic [CntW-1:0] l0_cap;
    logic [AgeW-1:0] rescue_limit;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] flush_cnt;
    logic [CntW-1:0] l0_cnt;
  } cnt_t;

  typedef struct packed {
    queue_e queue;
    cnt_t cnt;
  } pick_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

  function automatic logic cpu_has_counters(input logic [CpuIdxW-1:0] cpu);
    return ({19'd0, cpu} < 25'(CPUS));
  endfunction

endpackage

[hdl/bpqs_cfg_regs.sv]
module bpqs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpqs_pkg::PaddrW-1:0]   paddr,
  input  logic [bpqs_pkg::PdataW-1:0]   pwdata,
  output logic [bpqs_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output bpqs_pkg::cfg_t                cfg_o
);
  import bpqs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx = reg_idx_e'(paddr[PaddrW-1:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flush_cap <= DefFlushBudget;
      cfg_q.l0_cap <= DefL0Budget;
      cfg_q.rescue_limit <= DefRescueAge;
    end else if (wr_en) begin
      case (idx)
        RegFlushBudget: cfg_q.flush_cap <= pwdata[CntW-1:0];
        RegL0Budget:    cfg_q.l0_cap <= pwdata[CntW-1:0];
        RegRescueAge:   cfg_q.rescue_limit <= pwdata[AgeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegFlushBudget: prdata = {{(PdataW-CntW){1'b0}}, cfg_q.flush_cap};
      RegL0Budget:    prdata = {{(PdataW-CntW){1'b0}}, cfg_q.l0_cap};
      RegRescueAge:   prdata = {{(PdataW-AgeW){1'b0}}, cfg_q.rescue_limit};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bpqs_cnt_store.sv]
module bpqs_cnt_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [bpqs_pkg::StoreAddrW-1:0]   rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [bpqs_pkg::StoreAddrW-1:0]   wr_addr_i,
  input  bpqs_pkg::cnt_t                    wr_data_i,
  output bpqs_pkg::cnt_t                    rd_data_o
);
  import bpqs_pkg::*;

  cnt_t                  mem [StoreDepth];
  logic [StoreDepth-1:0] valid_q;
  cnt_t                  rd_q;
  logic                  rd_valid_q;
  cnt_t                  fwd_data_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // An entry never written reads as zero, which is the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        // The read races the write of the previous transaction to the same CPU.
        fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

[hdl/bpqs_pick.sv]
module bpqs_pick (
  input  bpqs_pkg::cfg_t              cfg_i,
  input  logic                        have_i,
  input  bpqs_pkg::cnt_t              cnt_i,
  input  logic                        flush_pending_i,
  input  logic                        l0_pending_i,
  input  logic                        comp_pending_i,
  input  logic                        shared_pending_i,
  input  logic                        shared_head_valid_i,
  input  logic [bpqs_pkg::AgeW-1:0]   shared_head_age_i,
  output bpqs_pkg::pick_t             pick_o
);
  import bpqs_pkg::*;

  logic [CntW-1:0] fb;
  logic [CntW-1:0] lb;
  logic [CntW-1:0] fc;
  logic [CntW-1:0] lc;
  logic            flush_out;
  logic            l0_out;
  logic            rescue;

  assign fb = (cfg_i.flush_cap == '0) ? DefFlushBudget : cfg_i.flush_cap;
  assign lb = (cfg_i.l0_cap == '0) ? DefL0Budget : cfg_i.l0_cap;
  assign fc = have_i ? cnt_i.flush_cnt : '0;
  assign lc = have_i ? cnt_i.l0_cnt : '0;
  assign flush_out = have_i && (fc >= fb);
  assign l0_out = have_i && (lc >= lb);
  assign rescue = shared_pending_i && shared_head_valid_i &&
                  (shared_head_age_i >= cfg_i.rescue_limit);

  always_comb begin
    pick_o.queue = QNone;
    pick_o.cnt.flush_cnt = fc;
    pick_o.cnt.l0_cnt = lc;
    if (flush_out && l0_pending_i) begin
      pick_o.queue = QL0;
      pick_o.cnt.flush_cnt = '0;
      pick_o.cnt.l0_cnt = sat_inc(lc);
    end else if ((flush_out || l0_out) && comp_pending_i) begin
      pick_o.queue = QComp;
      pick_o.cnt = '0;
    end else if ((flush_out || l0_out) && shared_pending_i) begin
      pick_o.queue = QShared;
      pick_o.cnt = '0;
    end else if (flush_pending_i) begin
      pick_o.queue = QFlush;
      pick_o.cnt.flush_cnt = sat_inc(fc);
      pick_o.cnt.l0_cnt = '0;
    end else if (l0_pending_i) begin
      pick_o.queue = QL0;
      pick_o.cnt.flush_cnt = '0;
      pick_o.cnt.l0_cnt = sat_inc(lc);
    end else if (rescue) begin
      pick_o.queue = QRescue;
    end else if (comp_pending_i) begin
      pick_o.queue = QComp;
      pick_o.cnt = '0;
    end else if (shared_pending_i) begin
      pick_o.queue = QFallback;
    end
  end

endmodule

[hdl/budgeted_priority_queue_selector.sv]
// An accepted transaction passes the stage-1 registers, then the result register.
// Throughput: one transaction per cycle unless ready_i stalls; the per-CPU counter
// store is read on accept and written on the move to the result, with forwarding.
// Reset clears the counter valid bits, so all counters read as zero, and sets
// the budget and rescue registers to their defaults. No clearing pass is needed.
module budgeted_priority_queue_selector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpqs_pkg::PaddrW-1:0]       paddr,
  input  logic [bpqs_pkg::PdataW-1:0]       pwdata,
  output logic [bpqs_pkg::PdataW-1:0]       prdata,
  output logic                              pready,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [bpqs_pkg::CpuIdxW-1:0]      cpu_index_i,
  input  logic                              flush_pending_i,
  input  logic                              l0_pending_i,
  input  logic                              comp_pending_i,
  input  logic                              shared_pending_i,
  input  logic                              shared_head_valid_i,
  input  logic [bpqs_pkg::AgeW-1:0]         shared_head_age_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [bpqs_pkg::QueueW-1:0]       chosen_queue_o,
  output logic [bpqs_pkg::CntW-1:0]         flush_run_now_o,
  output logic [bpqs_pkg::CntW-1:0]         l0_run_now_o
);
  import bpqs_pkg::*;

  cfg_t cfg;

  logic                s1_valid_q;
  logic [CpuIdxW-1:0]  s1_cpu_q;
  logic                s1_fp_q;
  logic                s1_lp_q;
  logic                s1_cp_q;
  logic                s1_sp_q;
  logic                s1_hv_q;
  logic [AgeW-1:0]     s1_age_q;

  logic                out_valid_q;
  pick_t               out_q;

  logic                accept;
  logic                advance;
  logic                s1_have;
  cnt_t                cur_cnt;
  pick_t               pick;

  assign advance = s1_valid_q && (!out_valid_q || ready_i);
  assign ready_o = !s1_valid_q || advance;
  assign accept = valid_i && ready_o;
  assign s1_have = cpu_has_counters(s1_cpu_q);

  bpqs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpqs_cnt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (cpu_index_i[StoreAddrW-1:0]),
    .wr_en_i   (advance && s1_have),
    .wr_addr_i (s1_cpu_q[StoreAddrW-1:0]),
    .wr_data_i (pick.cnt),
    .rd_data_o (cur_cnt)
  );

  bpqs_pick u_pick (
    .cfg_i               (cfg),
    .have_i              (s1_have),
    .cnt_i               (cur_cnt),
    .flush_pending_i     (s1_fp_q),
    .l0_pending_i        (s1_lp_q),
    .comp_pending_i      (s1_cp_q),
    .shared_pending_i    (s1_sp_q),
    .shared_head_valid_i (s1_hv_q),
    .shared_head_age_i   (s1_age_q),
    .pick_o              (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_valid_q <= valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cpu_q <= cpu_index_i;
      s1_fp_q <= flush_pending_i;
      s1_lp_q <= l0_pending_i;
      s1_cp_q <= comp_pending_i;
      s1_sp_q <= shared_pending_i;
      s1_hv_q <= shared_head_valid_i;
      s1_age_q <= shared_head_age_i;
    end
    if (advance) begin
      out_q <= pick;
    end
  end

  assign valid_o = out_valid_q;
  assign chosen_queue_o = out_q.queue;
  assign flush_run_now_o = out_q.cnt.flush_cnt;
  assign l0_run_now_o = out_q.cnt.l0_cnt;

endmodule
